// ----- sv/tdpt_pkg.sv -----
`default_nettype none

package tdpt_pkg;

    // Default width of the tested value.
    localparam int VALUE_WIDTH_DEF = 32;

    // Parallel remainder lanes. Each lane owns one odd divisor of a group.
    // Must stay a power of two: the square update below relies on it.
    localparam int LANES = 8;

    // Dividend bits consumed by every lane in one cycle with a step command.
    localparam int STEPS = 4;

    // Divisor step between groups, and the terms of the square update:
    // (d + 2*LANES)^2 = d^2 + (d << LANE_SQ_SHIFT) + SQ_INC.
    localparam int D_INC         = 2 * LANES;
    localparam int LANE_SQ_SHIFT = $clog2(4 * LANES);
    localparam int SQ_INC        = 4 * LANES * LANES;

    // First odd divisor tried.
    localparam int FIRST_DIV = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new word and set up the first group
        logic step;     // run one slice of the long division in every lane
        logic advance;  // move every lane to the next group of divisors
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;        // answer is known without any division
        logic trivial_prime;  // that answer (true only for two)
        logic in_range0;      // first lane's divisor squared fits under the value
        logic hit;            // some in-range lane left a zero remainder
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- sv/tdpt_datapath.sv -----
`default_nettype none

module tdpt_datapath #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    input  wire tdpt_pkg::t_dp_cmd             i_cmd,
    output tdpt_pkg::t_dp_sts                  o_sts
);

    // Divisors stay below 2^(VALUE_WIDTH/2) while the loop runs; two spare
    // bits cover the lanes of the last group and the final advance.
    localparam int D_WIDTH  = VALUE_WIDTH / 2 + 2;
    localparam int SQ_WIDTH = 2 * D_WIDTH;
    localparam int CYC      = (VALUE_WIDTH + tdpt_pkg::STEPS - 1) / tdpt_pkg::STEPS;
    localparam int SH_WIDTH = CYC * tdpt_pkg::STEPS;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [SH_WIDTH-1:0]    r_sh;
    logic [D_WIDTH-1:0]     r_div [tdpt_pkg::LANES];
    logic [SQ_WIDTH-1:0]    r_sq  [tdpt_pkg::LANES];
    logic [D_WIDTH-1:0]     r_rem [tdpt_pkg::LANES];
    logic [D_WIDTH-1:0]     n_rem [tdpt_pkg::LANES];

    logic [SQ_WIDTH-1:0]       w_value_ext;
    logic [tdpt_pkg::LANES-1:0] w_in_range;
    logic [tdpt_pkg::LANES-1:0] w_zero;

    assign w_value_ext = SQ_WIDTH'(r_value);

    // Restoring long division, STEPS bits per cycle while stepping, in every lane.
    always_comb begin
        logic [D_WIDTH:0]   t;
        logic [D_WIDTH-1:0] rem;
        t   = '0;
        rem = '0;
        for (int k = 0; k < tdpt_pkg::LANES; k++) begin
            rem = r_rem[k];
            for (int j = 0; j < tdpt_pkg::STEPS; j++) begin
                t = {rem, r_sh[SH_WIDTH-1-j]};
                if (t >= {1'b0, r_div[k]}) begin
                    rem = D_WIDTH'(t - {1'b0, r_div[k]});
                end else begin
                    rem = t[D_WIDTH-1:0];
                end
            end
            n_rem[k] = rem;
        end
    end

    always_comb begin
        for (int k = 0; k < tdpt_pkg::LANES; k++) begin
            w_in_range[k] = (r_sq[k] <= w_value_ext);
            w_zero[k]     = (r_rem[k] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= $unsigned(i_value);
            r_sh    <= SH_WIDTH'($unsigned(i_value));
            for (int k = 0; k < tdpt_pkg::LANES; k++) begin
                r_div[k] <= D_WIDTH'(tdpt_pkg::FIRST_DIV + 2 * k);
                r_sq[k]  <= SQ_WIDTH'((tdpt_pkg::FIRST_DIV + 2 * k)
                                      * (tdpt_pkg::FIRST_DIV + 2 * k));
                r_rem[k] <= '0;
            end
        end else if (i_cmd.advance) begin
            r_sh <= SH_WIDTH'(r_value);
            for (int k = 0; k < tdpt_pkg::LANES; k++) begin
                r_div[k] <= r_div[k] + D_WIDTH'(tdpt_pkg::D_INC);
                r_sq[k]  <= r_sq[k] + (SQ_WIDTH'(r_div[k]) << tdpt_pkg::LANE_SQ_SHIFT)
                            + SQ_WIDTH'(tdpt_pkg::SQ_INC);
                r_rem[k] <= '0;
            end
        end else if (i_cmd.step) begin
            r_sh <= r_sh << tdpt_pkg::STEPS;
            for (int k = 0; k < tdpt_pkg::LANES; k++) begin
                r_rem[k] <= n_rem[k];
            end
        end
    end

    // Negative, zero, one and every even value settle without division.
    assign o_sts.trivial = r_value[VALUE_WIDTH-1] || !r_value[0]
                           || (r_value[VALUE_WIDTH-1:1] == '0);
    assign o_sts.trivial_prime = (r_value == VALUE_WIDTH'(2));
    assign o_sts.in_range0     = w_in_range[0];
    assign o_sts.hit           = |(w_in_range & w_zero);

endmodule

`default_nettype wire

// ----- sv/tdpt_ctrl.sv -----
`default_nettype none

module tdpt_ctrl #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_prime,
    output tdpt_pkg::t_dp_cmd       o_cmd,
    input  wire tdpt_pkg::t_dp_sts  i_sts
);

    localparam int CYC       = (VALUE_WIDTH + tdpt_pkg::STEPS - 1) / tdpt_pkg::STEPS;
    localparam int CNT_WIDTH = $clog2(CYC);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BOUND = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                 r_answer, n_answer;
    logic                 r_out_valid, n_out_valid;
    logic                 r_prime, n_prime;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_answer    = r_answer;
        n_out_valid = r_out_valid && i_out_stall;
        n_prime     = r_prime;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BOUND;
                end
            end
            S_BOUND: begin
                if (i_sts.trivial) begin
                    n_answer = i_sts.trivial_prime;
                    n_state  = S_DONE;
                end else if (!i_sts.in_range0) begin
                    n_answer = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + CNT_WIDTH'(1);
                if (r_cnt == CNT_WIDTH'(CYC - 1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.hit) begin
                    n_answer = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_BOUND;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_prime     = r_answer;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_answer <= n_answer;
        r_prime  <= n_prime;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_prime     = r_prime;

endmodule

`default_nettype wire

// ----- sv/trial_division_prime_test.sv -----
// Trial-division primality test. Each word on the input channel is a signed
// two's complement value; for each one, exactly one word comes out on the
// output channel, with o_prime high if and only if the value is prime.
// Negative values, zero, one and every even value, two included, are
// answered without division. An odd value of three or more is divided by
// the odd divisors 3, 5, 7, ... up to and including the largest one whose
// square does not exceed the value, so odd prime squares such as 9 and 25
// correctly come out composite. Eight remainder lanes test eight
// consecutive odd divisors at once, each running a restoring long division
// over four dividend bits per cycle. For each group of eight divisors the
// controller checks the divisor bound, runs the division over the whole
// value in every lane, then looks for a zero remainder in an in-range lane.
// The block works on one value at a time: the input is stalled from the
// cycle after acceptance until the result has been moved into the output
// register, and the output register lets a new word be accepted while the
// previous result still waits to be taken.

`default_nettype none

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_prime
);

    // Command and status between the sequencer and the remainder lanes.
    tdpt_pkg::t_dp_cmd w_cmd;
    tdpt_pkg::t_dp_sts w_sts;

    // The controller owns the handshakes, the group loop and the result
    // register. It loads the datapath on acceptance, checks the trivial
    // cases and the divisor bound, runs one group of divisions, and either
    // stops on a zero remainder or advances to the next group.
    tdpt_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_prime     (o_prime),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // The datapath holds the value, the divisors of the current group, their
    // squares (kept up to date by shifts and additions only) and the running remainders.
    tdpt_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_value (i_value),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

`default_nettype wire

// ----- sim/tb_trial_division_prime_test.sv -----
`timescale 1ns / 1ps

module tb_trial_division_prime_test;

    localparam int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF;

    // Number of random words after the directed list.
    localparam int RANDOM_WORDS = 80;

    // At most this many random words are full-range odd positives.
    localparam int MAX_BIG_RANDOM = 6;

    // The last words on each side run with no idling at all.
    localparam int QUIET_TAIL = 15;

    // Once this many results have come back, the receiver holds off for a long
    // stretch. The sender goes on offering words between its idle bursts, so the block
    // ends up with a result parked in its output register and a second value
    // finished behind it, and it has to stall its input.
    localparam int PRESSURE_AFTER = 30;
    localparam int HOLD_CYCLES    = 2000;

    // Cycles allowed after the last expected result before the verdict.
    localparam int DRAIN_CYCLES = 50;

    // Slowest correct run: about nine values near 2^31 (three directed, at
    // most six random) whose division loop runs up to the divisor bound, and
    // every other word plus random idling on both sides.
    localparam int MAX_CYCLES = 2_000_000;

    // One answer waiting to come back. The value is kept for the error report.
    typedef struct {
        logic signed [VALUE_WIDTH-1:0] value;
        bit                            prime;
    } t_prime_answer;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic signed [VALUE_WIDTH-1:0] i_value     = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic                          o_prime;

    // Values still to be offered, and answers still to come back, in order.
    logic signed [VALUE_WIDTH-1:0] pending_values[$];
    t_prime_answer                 prime_answers[$];

    int total_words   = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int big_left      = MAX_BIG_RANDOM;

    // Idling and backpressure counters of the driver and the monitor.
    int  send_gap_left     = 0;
    int  stall_left        = 0;
    int  backpressure_left = 0;
    bit  backpressure_done = 1'b0;

    trial_division_prime_test #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_prime     (o_prime)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Primality by trial division. A set sign bit means a negative value,
    // which is never prime. Odd values from three up are divided by the odd
    // divisors while d <= v / d; that bound is inclusive, so squares of odd
    // primes come out composite, and it cannot overflow.
    function automatic bit is_prime_value(logic signed [VALUE_WIDTH-1:0] value);
        longint unsigned v;
        longint unsigned d;
        v = '0;
        v[VALUE_WIDTH-1:0] = value;
        if (value[VALUE_WIDTH-1]) return 1'b0;
        if (v <= 1) return 1'b0;
        if (v == 2) return 1'b1;
        if (v[0] == 1'b0) return 1'b0;
        for (d = 3; d <= v / d; d += 2) begin
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // One random word. Most of them are odd and positive, so they get past
    // the quick checks and into the division loop; small sizes keep the run
    // short. Squares of odd numbers and products of two odd numbers hit the
    // inclusive bound and late factors. The rest is noise: negative values,
    // even values over the full range, and a few full-range odd values.
    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        logic [31:0] word;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            word = $urandom_range(1, 32767) * 2 + 1;
        end else if (pick < 50) begin
            word = $urandom_range(32768, 2097151) * 2 + 1;
        end else if (pick < 65) begin
            a = $urandom_range(1, 2047) * 2 + 1;
            word = a * a;
        end else if (pick < 75) begin
            a = $urandom_range(1, 999) * 2 + 1;
            b = $urandom_range(1, 999) * 2 + 1;
            word = a * b;
        end else if (pick < 87) begin
            word = $urandom() | 32'h8000_0000;
        end else if (pick < 97) begin
            word = $urandom() & 32'h7FFF_FFFE;
        end else if (big_left > 0) begin
            big_left--;
            word = ($urandom() & 32'h7FFF_FFFF) | 32'h1;
        end else begin
            word = $urandom_range(1, 32767) * 2 + 1;
        end
        return word;
    endfunction

    // Stimulus list, reset and the end of the run.
    initial begin
        // Directed words: the ends of the range, the quick answers for
        // negative, zero, one, two and other even values, small primes, odd
        // prime squares right on the divisor bound, and the slowest cases
        // near the top of the range (the largest 32-bit prime, and the square
        // of the largest prime whose square still fits).
        pending_values.push_back(32'sh8000_0000);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'sd0);
        pending_values.push_back(32'sd1);
        pending_values.push_back(32'sd2);
        pending_values.push_back(32'sd3);
        pending_values.push_back(32'sd4);
        pending_values.push_back(32'sd5);
        pending_values.push_back(32'sd9);
        pending_values.push_back(32'sd15);
        pending_values.push_back(32'sd25);
        pending_values.push_back(32'sd49);
        pending_values.push_back(32'sd97);
        pending_values.push_back(32'sd121);
        pending_values.push_back(32'sd46337);
        pending_values.push_back(32'sd65521);
        pending_values.push_back(32'sd65537);
        pending_values.push_back(32'sh5555_5555);
        pending_values.push_back(32'sh2AAA_AAAA);
        pending_values.push_back(32'sh7FFF_FFFE);
        pending_values.push_back(32'sh7FFF_FFFF);
        pending_values.push_back(32'sd2147117569);
        pending_values.push_back(32'sd2147483629);
        repeat (RANDOM_WORDS) pending_values.push_back(random_value());
        total_words = pending_values.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every word gets its expected answer at the edge it is accepted, so
        // both queues run empty only once the last answer has been checked.
        while (pending_values.size() != 0 || prime_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Driver. A word that is offered stays on the port, unchanged, until it
    // is accepted. Between words the sender may idle for a random burst.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            send_gap_left <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                prime_answers.push_back('{value: i_value, prime: is_prime_value(i_value)});
                void'(pending_values.pop_front());
            end

            if (i_in_valid && o_in_stall) begin
                // Held: the same word is offered again.
            end else if (send_gap_left != 0) begin
                send_gap_left <= send_gap_left - 1;
                i_in_valid    <= 1'b0;
            end else if (pending_values.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_values.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                send_gap_left <= $urandom_range(0, 18);
                i_in_valid    <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_value    <= pending_values[0];
            end
        end
    end

    // Monitor. Each accepted result word is checked against the oldest
    // expected answer. The receiver stalls in random bursts, once for a long
    // stretch, and not at all near the end.
    always @(posedge i_clk) begin
        t_prime_answer expected;
        if (!i_rst_n) begin
            i_out_stall       <= 1'b0;
            stall_left        <= 0;
            backpressure_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (prime_answers.size() == 0) begin
                    $error("o_prime: unexpected word, expected none, actual %0b", o_prime);
                    error_count++;
                end else begin
                    expected = prime_answers.pop_front();
                    if (o_prime !== expected.prime) begin
                        $error("o_prime for value %0d: expected %0b, actual %0b",
                               expected.value, expected.prime, o_prime);
                        error_count++;
                    end
                end
                results_seen++;
            end

            if (backpressure_left != 0) begin
                backpressure_left <= backpressure_left - 1;
                i_out_stall       <= 1'b1;
            end else if (!backpressure_done && results_seen >= PRESSURE_AFTER) begin
                backpressure_done <= 1'b1;
                backpressure_left <= HOLD_CYCLES - 1;
                i_out_stall       <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (results_seen >= total_words - QUIET_TAIL) begin
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left  <= $urandom_range(0, 18);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a hung block or a lost word ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
